[hdl/multi_waveform_generator_macros.svh]
// Assertion macros for the multi-waveform generator checker.
// Each macro builds one labeled concurrent assertion with a reset disable.
`ifndef MULTI_WAVEFORM_GENERATOR_MACROS_SVH
`define MULTI_WAVEFORM_GENERATOR_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mwg_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the waveform generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mwg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int AMP_BITS        = 15;
    localparam int WAVE_BITS       = 2;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 32;

    localparam int QTR_ADDR_BITS = TABLE_ADDR_BITS - 2;
    localparam int QTR_LEN       = 2 ** QTR_ADDR_BITS;
    localparam int TAB_BITS      = SAMPLE_BITS - 1;

    localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
    localparam longint unsigned HALF_SCALE = 64'd1 << (SAMPLE_BITS - 1);

    // Reciprocals of the Taylor step divisors (2n)(2n+1) for n = 1 to 7. A term
    // never exceeds 32 bits, so a multiply and a shift by 40 give the exact
    // truncated quotient for every divisor up to 256.
    localparam int TAYLOR_SHIFT = 40;
    localparam longint unsigned TAYLOR_RECIP [7] = '{
        ((64'd1 << TAYLOR_SHIFT) + 64'd5) / 64'd6,
        ((64'd1 << TAYLOR_SHIFT) + 64'd19) / 64'd20,
        ((64'd1 << TAYLOR_SHIFT) + 64'd41) / 64'd42,
        ((64'd1 << TAYLOR_SHIFT) + 64'd71) / 64'd72,
        ((64'd1 << TAYLOR_SHIFT) + 64'd109) / 64'd110,
        ((64'd1 << TAYLOR_SHIFT) + 64'd155) / 64'd156,
        ((64'd1 << TAYLOR_SHIFT) + 64'd209) / 64'd210
    };

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SELECT  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET = CFG_INDEX_BITS'(3);

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = PHASE_BITS'(85899346);
    localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET  = AMP_BITS'(16384);

    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_SINE,
        WAVE_SQUARE,
        WAVE_TRIANGLE,
        WAVE_SAW
    } wave_t;

    // Settings the back end needs from the register file.
    typedef struct packed {
        wave_t               wave;
        logic [AMP_BITS-1:0] amplitude;
    } shape_cfg_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  wrap;
    } phase_item_t;

    typedef logic [QTR_LEN-1:0][TAB_BITS-1:0] qtab_t;

    // Quarter-wave sine table, evaluated at elaboration: a Taylor series in Q30
    // with truncating products, scaled to full positive range and rounded half up.
    function automatic qtab_t build_qtab();
        qtab_t             tab;
        longint unsigned   x;
        longint unsigned   t;
        longint unsigned   e;
        longint            sum;
        logic [127:0]      wide;
        int                k;
        int                n;
        tab = '0;
        for (k = 0; k < QTR_LEN; k++) begin
            x   = (PIHALF_Q30 * longint'(2 * k + 1)) >> (QTR_ADDR_BITS + 1);
            t   = x;
            sum = longint'(x);
            for (n = 1; n <= 7; n++) begin
                t    = (t * x) >> 30;
                t    = (t * x) >> 30;
                wide = {64'd0, t} * {64'd0, TAYLOR_RECIP[n-1]};
                t    = wide[TAYLOR_SHIFT +: 64];
                if (n[0]) begin
                    sum = sum - longint'(t);
                end
                else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = (longint'(sum) * (HALF_SCALE - 1) + (64'd1 << 29)) >> 30;
            if (e > HALF_SCALE - 1) begin
                e = HALF_SCALE - 1;
            end
            tab[k] = e[TAB_BITS-1:0];
        end
        return tab;
    endfunction

    localparam qtab_t QTR_TAB = build_qtab();

endpackage

`default_nettype wire

[hdl/multi_waveform_generator.sv]
// Multi-waveform DDS generator: sine, square, triangle and sawtooth samples.
// Top level tying the front end, the phase queue and the back end; uses mwg_pkg.
//
// Usage:
// The input side looks like a queue. Each beat pushed (push high, full low)
// is one sample tick; its restart bit zeroes the phase accumulator before that
// sample's phase is formed. The accumulator then advances by phase_step, and
// the carry out of that add is returned with the sample as period_wrap.
// The output side also looks like a queue: while empty is low the oldest
// result sits on sample and period_wrap, and a beat leaves when pop is high.
// Registers (wave_select, phase_step, amplitude, phase_offset) are written
// over the cfg channel, which is always ready; write them only while idle.
// Throughput is one beat per cycle while full is low. A pushed beat passes
// through the phase queue and the registered shape stage, with the amplitude
// multiply feeding the result queue directly.
// When the receiver stalls, the result queue and then the phase queue fill
// (four entries each) and full rises; nothing is dropped. Reset clears both
// queues and the accumulator and loads the register reset values.
`default_nettype none

module multi_waveform_generator (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire  [mwg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire  [mwg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  wire                                     push,
    output logic                                    full,
    input  wire                                     restart,
    input  wire                                     pop,
    output logic                                    empty,
    output logic signed [mwg_pkg::SAMPLE_BITS-1:0]  sample,
    output logic                                    period_wrap
);
    import mwg_pkg::*;

    // Front to queue.
    logic        q_push;
    logic        q_full;
    phase_item_t q_item;
    // Queue to back.
    logic        q_pop;
    logic        q_empty;
    phase_item_t q_head;
    // Register settings used by the back end.
    shape_cfg_t  shape_cfg;

    mwg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .restart   (restart),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item),
        .shape_cfg (shape_cfg)
    );

    mwg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_item  (q_item),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    mwg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .shape_cfg   (shape_cfg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .sample      (sample),
        .period_wrap (period_wrap)
    );

endmodule

`default_nettype wire

[hdl/mwg_front.sv]
// Front end: configuration registers, phase accumulator and item classification.
// Depends on mwg_pkg.
`default_nettype none

module mwg_front (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [mwg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire  [mwg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  wire                                    push,
    input  wire                                    restart,
    output logic                                   full,
    input  wire                                    q_full,
    output logic                                   q_push,
    output mwg_pkg::phase_item_t                   q_item,
    output mwg_pkg::shape_cfg_t                    shape_cfg
);
    import mwg_pkg::*;

    wave_t                 wave_select_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [AMP_BITS-1:0]   amplitude_reg;
    logic [PHASE_BITS-1:0] phase_offset_reg;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] acc_base;
    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wave_select_reg  <= WAVE_SINE;
            phase_step_reg   <= PHASE_STEP_RESET;
            amplitude_reg    <= AMPLITUDE_RESET;
            phase_offset_reg <= '0;
        end
        else if (cfg_write) begin
            case (cfg_index)
                REG_WAVE_SELECT:  wave_select_reg  <= wave_t'(cfg_data[WAVE_BITS-1:0]);
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[PHASE_BITS-1:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[AMP_BITS-1:0];
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[PHASE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

    // A restart zeroes the accumulator before this sample's phase is formed.
    always_comb begin
        acc_base              = restart ? '0 : acc_reg;
        q_item.phase          = acc_base + phase_offset_reg;
        {q_item.wrap, acc_next} = {1'b0, acc_base} + {1'b0, phase_step_reg};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            acc_reg <= '0;
        end
        else if (q_push) begin
            acc_reg <= acc_next;
        end
    end

    assign shape_cfg.wave      = wave_select_reg;
    assign shape_cfg.amplitude = amplitude_reg;

endmodule

`default_nettype wire

[hdl/mwg_queue.sv]
// Short queue of phase items between the front and the back end.
// Depends on mwg_pkg.
`default_nettype none

module mwg_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_push,
    input  mwg_pkg::phase_item_t   q_item,
    output logic                   q_full,
    input  wire                    q_pop,
    output mwg_pkg::phase_item_t   q_head,
    output logic                   q_empty
);
    import mwg_pkg::*;

    localparam int MQ_DEPTH    = 4;
    localparam int MQ_PTR_BITS = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_BITS = $clog2(MQ_DEPTH + 1);

    phase_item_t            slot_reg [MQ_DEPTH];
    logic [MQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [MQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [MQ_CNT_BITS-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign q_full  = (count_reg == MQ_CNT_BITS'(MQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mwg_back.sv]
// Back end: shape stage, amplitude multiply stage and the result queue.
// Depends on mwg_pkg.
`default_nettype none

module mwg_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  mwg_pkg::shape_cfg_t                  shape_cfg,
    input  wire                                  q_empty,
    input  mwg_pkg::phase_item_t                 q_head,
    output logic                                 q_pop,
    input  wire                                  pop,
    output logic                                 empty,
    output logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                 period_wrap
);
    import mwg_pkg::*;

    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);
    localparam int EXT_BITS    = SAMPLE_BITS + 2;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SHAPE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SHAPE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [EXT_BITS-1:0] H_EXT       = EXT_BITS'(HALF_SCALE);
    localparam logic signed [EXT_BITS-1:0] THREE_H_EXT = EXT_BITS'(3 * HALF_SCALE);
    localparam logic signed [EXT_BITS-1:0] MAX_EXT     = EXT_BITS'(HALF_SCALE - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          wrap;
    } result_t;

    // Stage one: shape word.
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_shape_reg;
    logic                          s1_wrap_reg;

    logic [SAMPLE_BITS-1:0]        u;
    logic [TABLE_ADDR_BITS-1:0]    tidx;
    logic [QTR_ADDR_BITS-1:0]      tk;
    logic [TAB_BITS-1:0]           tab_val;
    logic signed [SAMPLE_BITS-1:0] sine_val;
    logic signed [EXT_BITS-1:0]    tri_ext;
    logic signed [SAMPLE_BITS-1:0] shape;

    // Stage two: scaled sample into the result queue.
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   prod_sh;

    result_t                oq_reg [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0] oq_wr_reg;
    logic [OQ_PTR_BITS-1:0] oq_rd_reg;
    logic [OQ_CNT_BITS-1:0] oq_cnt_reg;
    logic                   oq_pop;
    logic [OQ_CNT_BITS:0]   oq_claimed;

    always_comb begin
        u    = q_head.phase[PHASE_BITS-1 -: SAMPLE_BITS];
        tidx = q_head.phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        tk   = tidx[QTR_ADDR_BITS-1:0];
        // Odd quadrants read the table backwards, the lower half turn is positive.
        if (tidx[TABLE_ADDR_BITS-2]) begin
            tk = ~tk;
        end
        tab_val  = QTR_TAB[tk];
        sine_val = $signed({1'b0, tab_val});
        if (tidx[TABLE_ADDR_BITS-1]) begin
            sine_val = -sine_val;
        end

        if (!u[SAMPLE_BITS-1]) begin
            tri_ext = $signed({1'b0, u, 1'b0}) - H_EXT;
        end
        else begin
            tri_ext = THREE_H_EXT - $signed({1'b0, u, 1'b0});
        end
        if (tri_ext > MAX_EXT) begin
            tri_ext = MAX_EXT;
        end

        case (shape_cfg.wave)
            WAVE_SINE:     shape = sine_val;
            WAVE_SQUARE:   shape = u[SAMPLE_BITS-1] ? SHAPE_MIN : SHAPE_MAX;
            WAVE_TRIANGLE: shape = tri_ext[SAMPLE_BITS-1:0];
            WAVE_SAW:      shape = {~u[SAMPLE_BITS-1], u[SAMPLE_BITS-2:0]};
            default:       shape = '0;
        endcase
    end

    // Only take an item when the result queue has room for it and the one in flight.
    assign oq_pop     = pop && !empty;
    assign oq_claimed = {1'b0, oq_cnt_reg} + (OQ_CNT_BITS+1)'(s1_valid_reg);
    assign q_pop      = !q_empty && (oq_claimed < (OQ_CNT_BITS+1)'(OQ_DEPTH));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= q_pop;
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            s1_shape_reg <= shape;
            s1_wrap_reg  <= q_head.wrap;
        end
    end

    // Arithmetic shift right floors, matching the scaling of the shape word.
    always_comb begin
        prod    = PROD_BITS'(s1_shape_reg) * $signed({1'b0, shape_cfg.amplitude});
        prod_sh = prod >>> (SAMPLE_BITS - 1);
    end

    always_ff @(posedge clk) begin
        if (s1_valid_reg) begin
            oq_reg[oq_wr_reg].sample <= prod_sh[SAMPLE_BITS-1:0];
            oq_reg[oq_wr_reg].wrap   <= s1_wrap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else begin
            if (s1_valid_reg) begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop) begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            if (s1_valid_reg && !oq_pop) begin
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            end
            else if (oq_pop && !s1_valid_reg) begin
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
            end
        end
    end

    assign empty       = (oq_cnt_reg == '0);
    assign sample      = oq_reg[oq_rd_reg].sample;
    assign period_wrap = oq_reg[oq_rd_reg].wrap;

endmodule

`default_nettype wire

[hdl/mwg_checker.sv]
// Port-level checker for the multi-waveform generator, bound to the top level.
// Depends on mwg_pkg and multi_waveform_generator_macros.svh.
`default_nettype none
`include "multi_waveform_generator_macros.svh"

module mwg_checker (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_valid,
    input  wire                                     cfg_ready,
    input  wire  [mwg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire  [mwg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  wire                                     push,
    input  wire                                     full,
    input  wire                                     restart,
    input  wire                                     pop,
    input  wire                                     empty,
    input  wire  signed [mwg_pkg::SAMPLE_BITS-1:0]  sample,
    input  wire                                     period_wrap
);
    import mwg_pkg::*;

    logic signed [SAMPLE_BITS-1:0] most_negative;
    logic                          unused_ok;

    assign most_negative = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign unused_ok     = cfg_valid ^ (|cfg_index) ^ (|cfg_data) ^ push ^ restart;

    // A waiting result may not vanish before it is popped.
    `MWG_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty, "result lost while stalled")

    // A stalled result keeps its value.
    `MWG_ASSERT_NEXT(a_payload_stable, clk, rst_n, !empty && !pop, $stable(sample) && $stable(period_wrap), "result changed while stalled")

    // The register port never back-pressures.
    `MWG_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "cfg_ready dropped")

    // Amplitude is at most 15 bits, so scaling can never reach the most negative code.
    `MWG_ASSERT_NOW(a_sample_range, clk, rst_n, !empty, sample != most_negative, "sample out of range")

    // Full only rises after a push has been taken while the input side had room.
    `MWG_ASSERT_NOW(a_full_cause, clk, rst_n, $rose(full), $past(push) && !$past(full) && (unused_ok || !unused_ok), "full rose without a push")

endmodule

bind multi_waveform_generator mwg_checker u_mwg_checker (.*);

`default_nettype wire
